// File: design/tdpp_pkg.sv
// Shared types, codes and constants of the tagged decimal pose parser.
package tdpp_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned VALUE_W       = 26;
	localparam int unsigned FIELD_W       = 2;
	localparam int unsigned OUT_TDATA_W   = 32;
	localparam int unsigned CFG_INDEX_W   = 2;
	localparam int unsigned DIGIT_COUNT_DEF = 6;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'd45;

	localparam logic [BYTE_W-1:0] TAG_FIRST_RST  = 8'd120;
	localparam logic [BYTE_W-1:0] TAG_SECOND_RST = 8'd121;
	localparam logic [BYTE_W-1:0] TAG_THIRD_RST  = 8'd116;

	localparam logic [CFG_INDEX_W-1:0] REG_TAG_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TAG_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TAG_THIRD  = 2'd2;

	localparam logic [FIELD_W-1:0] FIELD_FIRST  = 2'd0;
	localparam logic [FIELD_W-1:0] FIELD_SECOND = 2'd1;
	localparam logic [FIELD_W-1:0] FIELD_THIRD  = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SIGN,
		PH_DIGITS
	} tdpp_phase_t;

	typedef struct packed {
		logic [FIELD_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} tdpp_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] third;
	} tdpp_tags_t;

endpackage

// File: design/tagged_decimal_pose_parser_core.sv
// Top level of the tagged decimal pose parser: channels, tag registers, parser, output buffer.
// Usage:
//   s_* carries one received serial byte per beat in s_tdata[7:0]. The parser
//   hunts for the tag of the expected field (first, second, third, then first
//   again), takes an optional '-' and then DIGIT_COUNT digit bytes, and emits
//   one result beat per completed field on m_*: the value in m_tdata[25:0]
//   (two's complement, zero filled to 32 bits), the field index in m_tuser,
//   and m_tlast set on the third field of a frame. Bytes are not checked for
//   being digits; each adds (byte - 48) times its decimal weight.
//   cfg_* writes the three tag bytes (index 0, 1, 2); writes to index 3 are
//   taken and dropped. cfg_ready is always high; write only while idle.
// Throughput and registering:
//   One byte per cycle while s_tready is high. The parser state is one register stage;
//   a completed field goes into the output register, or the skid entry while that is held.
// Reset:
//   arst_n clears the parser to hunting for the first tag, restores the
//   default tags 'x', 'y', 't' and empties the output buffer.
// Stall:
//   An output register plus one skid entry hold results; s_tready drops only
//   while both are occupied, so bytes keep flowing while one result waits.
module tagged_decimal_pose_parser_core
	import tdpp_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Byte input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [25:0] field_value, [31:26] zero
	output logic [FIELD_W-1:0]     m_tuser,   // [1:0] field_index
	output logic                   m_tlast,   // frame_end
	// Configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]      cfg_data
);

	tdpp_tags_t   tags_q;
	logic         step;
	logic         emit;
	logic         space;
	tdpp_result_t result;
	tdpp_result_t out_data;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tags_q.first  <= TAG_FIRST_RST;
			tags_q.second <= TAG_SECOND_RST;
			tags_q.third  <= TAG_THIRD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TAG_FIRST:  tags_q.first  <= cfg_data;
				REG_TAG_SECOND: tags_q.second <= cfg_data;
				REG_TAG_THIRD:  tags_q.third  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Take a byte whenever the skid entry is free.
	assign s_tready = space;
	assign step     = s_tvalid && s_tready;

	tdpp_field_parser #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (s_tdata),
		.tags    (tags_q),
		.emit    (emit),
		.result  (result)
	);

	tdpp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {{(OUT_TDATA_W - VALUE_W){1'b0}}, out_data.value};
	assign m_tuser = out_data.index;
	assign m_tlast = out_data.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == FIELD_THIRD)))
		else $error("frame end does not match third field");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && m_tready) |=> m_tvalid)
		else $error("skid entry lost on output advance");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("emitted result not visible");

endmodule

// File: design/tdpp_field_parser.sv
// Tag hunt, sign detection and decimal accumulation, one byte per cycle while step is high.
module tdpp_field_parser
	import tdpp_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  tdpp_tags_t        tags,
	output logic              emit,
	output tdpp_result_t      result
);

	localparam int unsigned CNT_W = $clog2(DIGIT_COUNT + 1);

	tdpp_phase_t         phase_q, phase_d;
	logic [FIELD_W-1:0]  field_q, field_d;
	logic [CNT_W-1:0]    digits_q, digits_d;
	logic                neg_q, neg_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;

	logic [FIELD_W-1:0]  field_eff;
	logic [BYTE_W-1:0]   tag_exp;
	logic                tag_hit;
	logic                is_minus;
	logic                neg_eff;
	logic [VALUE_W-1:0]  acc_x10;
	logic [VALUE_W-1:0]  weight;
	logic [VALUE_W-1:0]  acc_new;
	logic [CNT_W-1:0]    digits_inc;
	logic                field_done;
	logic                take_digit;

	// Unused field code counts as the first field.
	always_comb begin
		unique case (field_q)
			FIELD_SECOND: field_eff = FIELD_SECOND;
			FIELD_THIRD:  field_eff = FIELD_THIRD;
			default:      field_eff = FIELD_FIRST;
		endcase
	end

	always_comb begin
		unique case (field_eff)
			FIELD_SECOND: tag_exp = tags.second;
			FIELD_THIRD:  tag_exp = tags.third;
			default:      tag_exp = tags.first;
		endcase
	end

	assign tag_hit    = (rx_byte == tag_exp);
	assign is_minus   = (rx_byte == MINUS_BYTE);
	assign take_digit = (phase_q == PH_DIGITS) || (phase_q == PH_SIGN && !is_minus);
	assign neg_eff    = (phase_q == PH_SIGN) ? 1'b0 : neg_q;
	assign acc_x10    = (acc_q << 3) + (acc_q << 1);
	assign weight     = {{(VALUE_W - BYTE_W){1'b0}}, rx_byte}
	                  - {{(VALUE_W - BYTE_W){1'b0}}, ASCII_ZERO};
	assign acc_new    = neg_eff ? (acc_x10 - weight) : (acc_x10 + weight);
	assign digits_inc = digits_q + CNT_W'(1);
	assign field_done = take_digit && (digits_inc == CNT_W'(DIGIT_COUNT));

	// Next phase.
	always_comb begin
		unique case (phase_q)
			PH_SIGN: begin
				if (is_minus) phase_d = PH_DIGITS;
				else if (field_done) phase_d = PH_HUNT;
				else phase_d = PH_DIGITS;
			end
			PH_DIGITS: phase_d = field_done ? PH_HUNT : PH_DIGITS;
			default:   phase_d = tag_hit ? PH_SIGN : PH_HUNT;
		endcase
	end

	// Datapath and result.
	always_comb begin
		field_d  = field_eff;
		digits_d = digits_q;
		neg_d    = neg_q;
		acc_d    = acc_q;
		if (phase_q == PH_SIGN || phase_q == PH_DIGITS) begin
			if (phase_q == PH_SIGN && is_minus) begin
				neg_d = 1'b1;
			end else if (field_done) begin
				digits_d = '0;
				neg_d    = 1'b0;
				acc_d    = '0;
				field_d  = (field_eff == FIELD_THIRD) ? FIELD_FIRST : field_eff + FIELD_W'(1);
			end else begin
				digits_d = digits_inc;
				neg_d    = neg_eff;
				acc_d    = acc_new;
			end
		end else if (tag_hit) begin
			digits_d = '0;
			neg_d    = 1'b0;
			acc_d    = '0;
		end
	end

	assign emit         = step && field_done;
	assign result.index = field_eff;
	assign result.value = acc_new;
	assign result.last  = (field_eff == FIELD_THIRD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			field_q  <= FIELD_FIRST;
			digits_q <= '0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			field_q  <= field_d;
			digits_q <= digits_d;
			neg_q    <= neg_d;
			acc_q    <= acc_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (digits_q == '0))
		else $error("digit count not cleared while hunting");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_HUNT && tag_hit) |=> (phase_q == PH_SIGN && acc_q == '0))
		else $error("tag match did not open a field");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (phase_q == PH_HUNT && field_q != $past(field_q)))
		else $error("field did not advance after result");

endmodule

// File: design/tdpp_out_skid.sv
// Output register with one skid entry for result beats.
module tdpp_out_skid
	import tdpp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tdpp_result_t push_data,
	output logic         space,
	output logic         out_valid,
	input  logic         out_ready,
	output tdpp_result_t out_data
);

	logic         main_valid_q;
	logic         skid_valid_q;
	tdpp_result_t main_q;
	tdpp_result_t skid_q;
	logic         pop;
	logic         main_free;

	assign pop       = main_valid_q && out_ready;
	assign main_free = pop || !main_valid_q;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (main_free) begin
				main_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload: advance skid into main first, keep order.
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (push) main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
